// ===== hw/rtl/bmo_pkg.sv =====
// bmo_pkg: constants, types and the cordic arctangent table for the odometry block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package bmo_pkg;

    localparam int SPEED_W = 16;
    localparam int STEER_W = 16;
    localparam int DT_W    = 20;
    localparam int WB_W    = 12;
    localparam int POS_W   = 48;
    localparam int ANG_W   = 32;
    localparam int Q_W     = 16;
    localparam int YAW_W   = 24;
    localparam int CW      = 34;   // cordic datapath, q2.30 plus headroom
    localparam int ZW      = 33;   // residual angle
    localparam int ACC_W   = 72;   // shared accumulator
    localparam int MUL_W   = 36;   // shared multiplier operand width

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 200;

    localparam logic [WB_W-1:0] WB_RESET = 12'd370;
    localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032875;
    localparam logic signed [ACC_W-1:0] POS_MAX = 72'sd140737488355327;
    localparam logic signed [ACC_W-1:0] POS_MIN = -72'sd140737488355328;
    localparam logic signed [ACC_W-1:0] YAW_MAX = 72'sd8388607;
    localparam logic signed [ACC_W-1:0] YAW_MIN = -72'sd8388608;

    function automatic logic [ANG_W-1:0] atan_entry(input logic [4:0] i);
        logic [ANG_W-1:0] r;
        begin
            case (i)
                5'd0:  r = 32'd536870912;
                5'd1:  r = 32'd316933406;
                5'd2:  r = 32'd167458907;
                5'd3:  r = 32'd85004756;
                5'd4:  r = 32'd42667331;
                5'd5:  r = 32'd21354465;
                5'd6:  r = 32'd10679838;
                5'd7:  r = 32'd5340245;
                5'd8:  r = 32'd2670163;
                5'd9:  r = 32'd1335087;
                5'd10: r = 32'd667544;
                5'd11: r = 32'd333772;
                5'd12: r = 32'd166886;
                5'd13: r = 32'd83443;
                5'd14: r = 32'd41722;
                5'd15: r = 32'd20861;
                5'd16: r = 32'd10430;
                5'd17: r = 32'd5215;
                5'd18: r = 32'd2608;
                5'd19: r = 32'd1304;
                5'd20: r = 32'd652;
                5'd21: r = 32'd326;
                5'd22: r = 32'd163;
                5'd23: r = 32'd81;
                5'd24: r = 32'd41;
                5'd25: r = 32'd20;
                5'd26: r = 32'd10;
                5'd27: r = 32'd5;
                5'd28: r = 32'd3;
                5'd29: r = 32'd1;
                5'd30: r = 32'd1;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bicycle_model_odometry.sv =====
// bicycle_model_odometry: fixed-point kinematic bicycle dead reckoning
// depends on bmo_pkg (widths, constants, cordic arctangent table)
//
//  channel  | direction | tdata / tuser
//  s_axis   | in        | speed[15:0] steering[31:16] elapsed_us[51:32]
//  m_axis   | out       | pos_x pos_y heading quat_z quat_w speed_out yaw_rate
//  cfg      | in        | wheelbase_mm[11:0]
//
// one tick, from accept to next accept, makes three passes of the shared cordic unit
// and runs a restoring divider for yaw rate; multiplies go one at a time through one
// 36x36 multiplier
// s_axis_tready is high in idle; a result waiting in the output register only
// stalls the next tick when that tick is done; reset clears state, wheelbase to 370
`timescale 1ns / 1ps
`default_nettype none
module bicycle_model_odometry
    import bmo_pkg::*;
#(
    parameter int CORDIC_STEPS = 24,
    parameter int HEADING_BITS = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // speed, steering, elapsed_us
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // pos_x, pos_y, heading,
                                                        // quat_z, quat_w, speed_out, yaw_rate
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [WB_W-1:0]        cfg_data
);

    localparam int SW = $clog2(CORDIC_STEPS + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_ANG, S_C1_INIT, S_C1_RUN, S_DEN, S_NUM1, S_NUM2, S_DIV_INIT, S_DIV_RUN,
        S_DIV_END, S_C2_INIT, S_C2_RUN, S_SD, S_PX, S_PY, S_PQ, S_DH1, S_DH2, S_DH3,
        S_DH4, S_C3_INIT, S_C3_RUN, S_OUT
    } state_t;

    state_t state_reg;
    logic [WB_W-1:0] wb_reg;
    logic signed [POS_W-1:0] px_reg, py_reg;
    logic [ANG_W-1:0] hd_reg;
    logic signed [SPEED_W-1:0] speed_reg;
    logic signed [STEER_W-1:0] steer_reg;
    logic [DT_W-1:0] dt_reg;
    // cordic
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic signed [ZW-1:0] cz_reg;
    logic [SW-1:0] step_reg;
    logic flip_reg;
    logic signed [CW-1:0] c_reg, s_reg;
    // shared multiply and accumulator
    logic signed [ACC_W-1:0] acc_reg, den_reg, sd_reg;
    logic signed [YAW_W-1:0] yaw_reg;
    // divider
    logic [ACC_W-1:0] rem_reg, quo_reg;
    logic [6:0] dcnt_reg;
    logic neg_reg;
    logic px_sel_reg;
    logic out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic signed [MUL_W-1:0] ma, mb;
    logic signed [ACC_W-1:0] prod;
    assign prod = ACC_W'(ma * mb);

    // cordic step
    logic signed [CW-1:0] dx, dy;
    logic [ANG_W-1:0] at;
    assign dx = cy_reg >>> step_reg;
    assign dy = cx_reg >>> step_reg;
    assign at = atan_entry(5'(step_reg));

    function automatic logic signed [ACC_W-1:0] sat(input logic signed [ACC_W-1:0] v,
        input logic signed [ACC_W-1:0] lo, input logic signed [ACC_W-1:0] hi);
        begin
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        end
    endfunction

    function automatic logic [Q_W-1:0] quat(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] t;
        begin
            t = (v + CW'(16384)) >>> 15;
            if (t > CW'(32767))
                return 16'h7fff;
            else if (t < -CW'(32768))
                return 16'h8000;
            else
                return t[Q_W-1:0];
        end
    endfunction

    // round to nearest, ties away, of acc / (1000*2^20)
    localparam logic [ACC_W-1:0] PDIV = ACC_W'(64'd1000 << 20);
    // ceil(2^40/125): (n >> 3) * RECIP_125 >> 40 equals n / 1000 for n >> 3 below 2^33
    localparam logic signed [MUL_W-1:0] RECIP_125 = 36'sd8796093023;
    logic [ACC_W-1:0] pabs;
    logic [ACC_W-1:0] pnum;
    logic signed [ACC_W-1:0] pquo, pstep;
    assign pabs  = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : acc_reg;
    assign pnum  = pabs + (PDIV >> 1);
    assign pquo  = prod >>> 40;
    assign pstep = neg_reg ? -pquo : pquo;

    logic [ANG_W-1:0] cang;
    logic [ACC_W-1:0] mask;
    assign mask = ~((ACC_W'(1) << (32 - HEADING_BITS)) - ACC_W'(1));

    always_comb
    begin
        unique case (state_reg)
            S_C1_INIT: cang = acc_reg[ANG_W-1:0];
            S_C2_INIT: cang = hd_reg;
            default:   cang = {1'b0, hd_reg[ANG_W-1:1]};
        endcase
    end

    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (state_reg)
            S_ANG:  begin ma = MUL_W'(steer_reg); mb = 36'sd2734261102; end
            S_DEN:  begin ma = MUL_W'($signed({1'b0, (wb_reg == '0) ? 12'd1 : wb_reg}));
                          mb = MUL_W'(c_reg); end
            S_NUM1: begin ma = MUL_W'(speed_reg); mb = 36'sd1000; end
            S_NUM2: begin ma = MUL_W'(acc_reg); mb = MUL_W'(s_reg); end
            S_SD:   begin ma = MUL_W'(speed_reg); mb = MUL_W'($signed({1'b0, dt_reg})); end
            S_PX:   begin ma = MUL_W'(sd_reg); mb = MUL_W'(c_reg >>> 10); end
            S_PY:   begin ma = MUL_W'(sd_reg); mb = MUL_W'(s_reg >>> 10); end
            S_PQ:   begin ma = $signed({1'b0, pnum[57:23]}); mb = RECIP_125; end
            S_DH1:  begin ma = MUL_W'($signed({1'b0, dt_reg})); mb = 36'sd44798; end
            S_DH2:  begin ma = MUL_W'(yaw_reg); mb = $signed({18'b0, acc_reg[17:0]}); end
            S_DH3:  begin ma = MUL_W'(yaw_reg); mb = $signed({18'b0, acc_reg[35:18]}); end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wb_reg        <= WB_RESET;
            px_reg        <= '0;
            py_reg        <= '0;
            hd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                wb_reg <= cfg_data;
            if (m_axis_tvalid && m_axis_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        speed_reg <= s_axis_tdata[15:0];
                        if ($signed(s_axis_tdata[31:16]) > 16'sd16384)
                            steer_reg <= 16'sd16384;
                        else if ($signed(s_axis_tdata[31:16]) < -16'sd16384)
                            steer_reg <= -16'sd16384;
                        else
                            steer_reg <= s_axis_tdata[31:16];
                        dt_reg    <= s_axis_tdata[51:32];
                        state_reg <= S_ANG;
                    end
                end
                S_ANG:
                begin
                    acc_reg   <= (prod + ACC_W'(32768)) >>> 16;
                    state_reg <= S_C1_INIT;
                end
                S_C1_INIT, S_C2_INIT, S_C3_INIT:
                begin
                    flip_reg <= cang[31] ^ cang[30];
                    cz_reg   <= $signed({cang[31] ^ (cang[31] ^ cang[30]),
                                         cang[31] ^ (cang[31] ^ cang[30]), cang[30:0]});
                    cx_reg   <= CORDIC_K;
                    cy_reg   <= '0;
                    step_reg <= '0;
                    state_reg <= (state_reg == S_C1_INIT) ? S_C1_RUN :
                                 (state_reg == S_C2_INIT) ? S_C2_RUN : S_C3_RUN;
                end
                S_C1_RUN, S_C2_RUN, S_C3_RUN:
                begin
                    if (step_reg == SW'(CORDIC_STEPS))
                    begin
                        c_reg <= flip_reg ? -cx_reg : cx_reg;
                        s_reg <= flip_reg ? -cy_reg : cy_reg;
                        state_reg <= (state_reg == S_C1_RUN) ? S_DEN :
                                     (state_reg == S_C2_RUN) ? S_SD : S_OUT;
                    end
                    else
                    begin
                        if (!cz_reg[ZW-1])
                        begin
                            cx_reg <= cx_reg - dx;
                            cy_reg <= cy_reg + dy;
                            cz_reg <= cz_reg - $signed({1'b0, at});
                        end
                        else
                        begin
                            cx_reg <= cx_reg + dx;
                            cy_reg <= cy_reg - dy;
                            cz_reg <= cz_reg + $signed({1'b0, at});
                        end
                        step_reg <= step_reg + SW'(1);
                    end
                end
                S_DEN:
                begin
                    den_reg   <= prod;
                    state_reg <= S_NUM1;
                end
                S_NUM1:
                begin
                    acc_reg   <= prod;
                    state_reg <= S_NUM2;
                end
                S_NUM2:
                begin
                    acc_reg   <= prod;
                    state_reg <= S_DIV_INIT;
                end
                S_DIV_INIT:
                begin
                    if (den_reg <= 0)
                    begin
                        yaw_reg   <= '0;
                        state_reg <= S_C2_INIT;
                    end
                    else
                    begin
                        neg_reg  <= acc_reg[ACC_W-1];
                        quo_reg  <= pabs + ACC_W'(den_reg >>> 1);
                        rem_reg  <= '0;
                        dcnt_reg <= 7'(ACC_W);
                        state_reg <= S_DIV_RUN;
                    end
                end
                S_DIV_RUN:
                begin
                    // restoring divide, one quotient bit per cycle
                    if ({rem_reg[ACC_W-2:0], quo_reg[ACC_W-1]} >= den_reg)
                        rem_reg <= {rem_reg[ACC_W-2:0], quo_reg[ACC_W-1]} - den_reg;
                    else
                        rem_reg <= {rem_reg[ACC_W-2:0], quo_reg[ACC_W-1]};
                    quo_reg <= {quo_reg[ACC_W-2:0],
                                ({rem_reg[ACC_W-2:0], quo_reg[ACC_W-1]} >= den_reg)};
                    dcnt_reg <= dcnt_reg - 7'd1;
                    if (dcnt_reg == 7'd1)
                        state_reg <= S_DIV_END;
                end
                S_DIV_END:
                begin
                    yaw_reg   <= YAW_W'(sat(neg_reg ? -$signed(quo_reg) : $signed(quo_reg),
                                           YAW_MIN, YAW_MAX));
                    state_reg <= S_C2_INIT;
                end
                S_SD:
                begin
                    sd_reg     <= prod;
                    px_sel_reg <= 1'b0;
                    state_reg  <= S_PX;
                end
                S_PX, S_PY:
                begin
                    px_sel_reg <= (state_reg == S_PY);
                    neg_reg    <= prod[ACC_W-1];
                    acc_reg    <= prod;
                    state_reg  <= S_PQ;
                end
                S_PQ:
                begin
                    if (!px_sel_reg)
                    begin
                        px_reg    <= POS_W'(sat(ACC_W'(px_reg) + pstep, POS_MIN, POS_MAX));
                        state_reg <= S_PY;
                    end
                    else
                    begin
                        py_reg    <= POS_W'(sat(ACC_W'(py_reg) + pstep, POS_MIN, POS_MAX));
                        state_reg <= S_DH1;
                    end
                end
                S_DH1:
                begin
                    acc_reg   <= prod;
                    state_reg <= S_DH2;
                end
                S_DH2:
                begin
                    // yaw * (dt*44798) split into high and low 18-bit halves
                    sd_reg    <= prod;
                    state_reg <= S_DH3;
                end
                S_DH3:
                begin
                    acc_reg   <= ((prod <<< 18) + sd_reg + ACC_W'(32768)) >>> 16;
                    state_reg <= S_DH4;
                end
                S_DH4:
                begin
                    hd_reg    <= ANG_W'((ACC_W'(hd_reg) + acc_reg) & mask);
                    state_reg <= S_C3_INIT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_data_reg <= {yaw_reg, speed_reg, quat(c_reg), quat(s_reg),
                                         hd_reg, py_reg, px_reg};
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = (state_reg == S_IDLE);

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_axis_tready)
        else $error("accept while busy");
    a_heading_mask: assert property (@(posedge clk) disable iff (!rst_n)
        ((ACC_W'(hd_reg) & ~mask) == '0))
        else $error("heading low bits set");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output changed while stalled");
`endif

endmodule
`default_nettype wire
